// ----- rtl/hex_paragraph_text_decoder_core_defines.svh -----
// Assertion macros shared by the hex text decoder RTL.
// Each macro expects signals named clock and reset in the including scope.
`ifndef HEX_PARAGRAPH_TEXT_DECODER_CORE_DEFINES_SVH
`define HEX_PARAGRAPH_TEXT_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HPTD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define HPTD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/hptd_pkg.sv -----
// Types, character constants and helper functions of the hex text decoder.
// Used by hptd_step and hex_paragraph_text_decoder_core; depends on nothing.
package hptd_pkg;

   localparam logic [15:0] MAX_LENGTH = 16'hFFFF;
   localparam logic [15:0] IP_PAYLOAD_LIMIT = 16'd65487;
   localparam int unsigned MAX_RESULTS = 3;

   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_E    = 8'h45;
   localparam logic [7:0] CH_M    = 8'h4D;
   localparam logic [7:0] CH_P    = 8'h50;
   localparam logic [7:0] CH_T    = 8'h54;
   localparam logic [7:0] CH_Y    = 8'h59;

   localparam logic [2:0] KW_NONE  = 3'd0;
   localparam logic [2:0] KW_E     = 3'd1;
   localparam logic [2:0] KW_FULL  = 3'd5;

   typedef enum logic [2:0] {
      KIND_BYTE  = 3'd0,
      KIND_END   = 3'd1,
      KIND_EMPTY = 3'd2,
      KIND_ERROR = 3'd3,
      KIND_DONE  = 3'd4
   } kind_type;

   typedef enum logic {
      ERR_BAD_HEX  = 1'b0,
      ERR_KEYWORD  = 1'b1
   } err_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      err_type     error_code;
      logic [15:0] packet_length;
      logic        oversize;
   } result_type;

   typedef struct packed {
      logic        nibble_held;
      logic [3:0]  high_nibble;
      logic        line_blank;
      logic [2:0]  keyword_pos;
      logic        in_comment;
      logic [15:0] current_length;
      logic [15:0] longest_length;
      logic        error_halt;
   } state_type;

   localparam state_type STATE_RESET = '{
      nibble_held:    1'b0,
      high_nibble:    4'h0,
      line_blank:     1'b1,
      keyword_pos:    KW_NONE,
      in_comment:     1'b0,
      current_length: 16'd0,
      longest_length: 16'd0,
      error_halt:     1'b0
   };

   localparam result_type RESULT_IDLE = '{
      kind:          KIND_BYTE,
      data_byte:     8'h00,
      error_code:    ERR_BAD_HEX,
      packet_length: 16'd0,
      oversize:      1'b0
   };

   function automatic logic is_alnum(input logic [7:0] ch);
      return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
             (ch >= 8'h61 && ch <= 8'h7A);
   endfunction

   function automatic logic is_space(input logic [7:0] ch);
      return (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
   endfunction

   // Bit 4 set means the character is not a hex digit.
   function automatic logic [4:0] hex_value(input logic [7:0] ch);
      logic [4:0] v;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         v = {1'b0, ch[3:0]};
      end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
         v = {1'b0, ch[3:0] + 4'd9};
      end else begin
         v = 5'h10;
      end
      return v;
   endfunction

   function automatic logic [7:0] keyword_char(input logic [2:0] pos);
      logic [7:0] c;
      unique case (pos)
         3'd0:    c = CH_E;
         3'd1:    c = CH_M;
         3'd2:    c = CH_P;
         3'd3:    c = CH_T;
         default: c = CH_Y;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/hptd_step.sv -----
// Decode logic for one character: next parser state and up to three results.
// Purely combinational; depends on hptd_pkg.
module hptd_step
   import hptd_pkg::*;
(
   input  state_type   st_cur,
   input  logic [7:0]  text_char,
   input  logic        end_of_input,
   input  logic        paragraph_mode,
   output state_type   st_next,
   output result_type  res [MAX_RESULTS],
   output logic [1:0]  res_count
);

   always_comb begin
      state_type  s;
      logic       alnum;
      logic       space;
      logic [4:0] hv;
      logic       run_decode;
      logic       skip;
      logic       do_put;
      logic [7:0] put_val;
      logic       do_close;
      logic       do_empty;
      logic       do_err;
      logic [7:0] err_char;
      err_type    err_code;
      logic [15:0] put_len;
      logic [15:0] close_len;
      logic [1:0] n;

      s          = st_cur;
      alnum      = is_alnum(text_char);
      space      = is_space(text_char);
      hv         = hex_value(text_char);
      run_decode = 1'b0;
      skip       = 1'b0;
      do_put     = 1'b0;
      put_val    = 8'h00;
      do_close   = 1'b0;
      do_empty   = 1'b0;
      do_err     = 1'b0;
      err_char   = CH_M;
      err_code   = ERR_KEYWORD;
      put_len    = 16'd0;
      close_len  = 16'd0;
      n          = 2'd0;

      if (end_of_input) begin
         if (!s.error_halt) begin
            if (s.keyword_pos == KW_E) begin
               s.nibble_held = 1'b1;
               s.high_nibble = 4'hE;
            end else if (s.keyword_pos == KW_FULL) begin
               do_empty = 1'b1;
            end else if (s.keyword_pos != KW_NONE) begin
               do_err       = 1'b1;
               s.error_halt = 1'b1;
            end
            if (!s.error_halt) begin
               if (s.nibble_held) begin
                  do_put  = 1'b1;
                  put_val = {4'h0, s.high_nibble};
               end
               do_close = (s.current_length != 16'd0) || do_put;
            end
         end
      end else if (s.error_halt) begin
         // Input is dropped until end of input.
      end else if (s.in_comment) begin
         if (text_char == CH_LF) begin
            s.in_comment = 1'b0;
            s.line_blank = 1'b1;
         end
      end else if (s.keyword_pos != KW_NONE) begin
         if (s.keyword_pos == KW_E && text_char != CH_M) begin
            // The lone E was a hex digit after all.
            s.keyword_pos = KW_NONE;
            s.nibble_held = 1'b1;
            s.high_nibble = 4'hE;
            s.line_blank  = 1'b0;
            run_decode    = 1'b1;
         end else if (s.keyword_pos < KW_FULL) begin
            if (text_char == keyword_char(s.keyword_pos)) begin
               s.keyword_pos = s.keyword_pos + 3'd1;
            end else begin
               s.keyword_pos = KW_NONE;
               do_err        = 1'b1;
               s.error_halt  = 1'b1;
            end
         end else begin
            s.keyword_pos = KW_NONE;
            if (!space && text_char != CH_HASH) begin
               do_err       = 1'b1;
               s.error_halt = 1'b1;
            end else begin
               do_close     = (s.current_length != 16'd0);
               do_empty     = 1'b1;
               s.line_blank = 1'b1;
               if (text_char != CH_LF) begin
                  s.in_comment = 1'b1;
               end
            end
         end
      end else begin
         run_decode = 1'b1;
      end

      if (run_decode) begin
         if (s.nibble_held) begin
            s.nibble_held = 1'b0;
            if (alnum) begin
               skip = 1'b1;
               if (hv[4]) begin
                  do_err       = 1'b1;
                  err_char     = text_char;
                  err_code     = ERR_BAD_HEX;
                  s.error_halt = 1'b1;
               end else begin
                  do_put        = 1'b1;
                  put_val       = {s.high_nibble, hv[3:0]};
                  s.high_nibble = 4'h0;
               end
            end else begin
               do_put        = 1'b1;
               put_val       = {4'h0, s.high_nibble};
               s.high_nibble = 4'h0;
            end
         end
         if (!skip) begin
            if (s.line_blank && text_char == CH_E) begin
               s.keyword_pos = KW_E;
            end else if (alnum) begin
               if (hv[4]) begin
                  do_err       = 1'b1;
                  err_char     = text_char;
                  err_code     = ERR_BAD_HEX;
                  s.error_halt = 1'b1;
               end else begin
                  s.nibble_held = 1'b1;
                  s.high_nibble = hv[3:0];
                  s.line_blank  = 1'b0;
               end
            end else if (text_char == CH_HASH || text_char == CH_LF) begin
               do_close = ((s.current_length != 16'd0) || do_put) &&
                          (!paragraph_mode || (text_char == CH_LF && s.line_blank));
               if (text_char == CH_HASH) begin
                  s.in_comment = 1'b1;
               end
               s.line_blank = 1'b1;
            end else if (!space) begin
               s.line_blank = 1'b0;
            end
         end
      end

      // Length bookkeeping in emission order: byte first, then packet end.
      if (do_put) begin
         if (s.current_length < MAX_LENGTH) begin
            s.current_length = s.current_length + 16'd1;
         end
         put_len = s.current_length;
      end
      if (do_close) begin
         close_len = s.current_length;
         if (s.longest_length < s.current_length) begin
            s.longest_length = s.current_length;
         end
         s.current_length = 16'd0;
      end

      for (int i = 0; i < MAX_RESULTS; i++) begin
         res[i] = RESULT_IDLE;
      end
      if (do_put) begin
         res[n].kind          = KIND_BYTE;
         res[n].data_byte     = put_val;
         res[n].packet_length = put_len;
         res[n].oversize      = put_len > IP_PAYLOAD_LIMIT;
         n = n + 2'd1;
      end
      if (do_close) begin
         res[n].kind          = KIND_END;
         res[n].packet_length = close_len;
         res[n].oversize      = close_len > IP_PAYLOAD_LIMIT;
         n = n + 2'd1;
      end
      if (do_empty && !do_err) begin
         res[n].kind = KIND_EMPTY;
         n = n + 2'd1;
      end
      if (do_err) begin
         res[n].kind       = KIND_ERROR;
         res[n].data_byte  = err_char;
         res[n].error_code = err_code;
         n = n + 2'd1;
      end
      if (end_of_input) begin
         res[n].kind          = KIND_DONE;
         res[n].packet_length = s.longest_length;
         res[n].oversize      = s.longest_length > IP_PAYLOAD_LIMIT;
         n = n + 2'd1;
         s = STATE_RESET;
      end

      st_next   = s;
      res_count = n;
   end

endmodule

// ----- rtl/hex_paragraph_text_decoder_core.sv -----
// Top level of the hex text decoder: input word register, decode step, result bundle.
// Depends on hptd_pkg, hptd_step and hex_paragraph_text_decoder_core_defines.svh.
//
// Use: one text character is sent per input word on the req_ channel (valid/stall),
// with req_end_of_input marking the end of a text; its character is then ignored.
// Each word yields zero to three result words on the rsp_ channel, the final one of
// them flagged by rsp_last. Payload bytes, packet ends, empty packets, errors and
// the closing input-done word carry kind, byte, error code, length and oversize.
// Path: an accepted word is held in the input register, then decoded by hptd_step
// into the result bundle register, from which its results are delivered.
// Throughput: one input word per cycle while rsp_stall is low and each word gives
// at most one result; a word with more than one result holds the single result port
// until all are taken, which sets the rate. Words that give no result pass through
// even while the bundle is waiting. The input register acts as the skid stage, so a new word
// is taken while a finished result is still waiting to be taken.
// Stall: while rsp_stall is high the bundle holds and the input register fills;
// req_stall then rises until the bundle drains.
// Reset: synchronous, active high. Parser state returns to its idle values and
// paragraph mode is set. csr_wr_en writes the mode bit; the user must use it only when idle (not enforced).
`include "hex_paragraph_text_decoder_core_defines.svh"

module hex_paragraph_text_decoder_core
   import hptd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_char,
   input  logic        req_end_of_input,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_error_code,
   output logic [15:0] rsp_packet_length,
   output logic        rsp_oversize,
   output logic        rsp_last,
   // Configuration
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   // Input word register.
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_char_ff;
   logic        in_eoi_ff;

   // Parser state and mode register.
   state_type   st_ff, st_in;
   logic        mode_ff, mode_in;

   // Result bundle: all results of one word, delivered one per handshake.
   result_type  bund_res_ff [MAX_RESULTS];
   logic        bund_valid_ff, bund_valid_in;
   logic [1:0]  bund_cnt_ff, bund_cnt_in;
   logic [1:0]  bund_idx_ff, bund_idx_in;

   result_type  step_res [MAX_RESULTS];
   logic [1:0]  step_cnt;
   logic        req_accept;
   logic        rsp_accept;
   logic        bund_done;
   logic        adv;
   logic        load_bund;
   result_type  cur_res;

   hptd_step u_step (
      .st_cur         (st_ff),
      .text_char      (in_char_ff),
      .end_of_input   (in_eoi_ff),
      .paragraph_mode (mode_ff),
      .st_next        (st_in),
      .res            (step_res),
      .res_count      (step_cnt)
   );

   assign rsp_accept = bund_valid_ff && !rsp_stall;
   assign bund_done  = rsp_accept && (bund_idx_ff == bund_cnt_ff - 2'd1);

   // The word in the input register is decoded once the bundle can take its
   // results, or at once when it has none.
   assign adv        = in_valid_ff && (!bund_valid_ff || bund_done || step_cnt == 2'd0);
   assign load_bund  = adv && (step_cnt != 2'd0);
   assign req_stall  = in_valid_ff && !adv;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (adv) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      bund_valid_in = bund_valid_ff;
      bund_cnt_in   = bund_cnt_ff;
      bund_idx_in   = bund_idx_ff;
      if (load_bund) begin
         bund_valid_in = 1'b1;
         bund_cnt_in   = step_cnt;
         bund_idx_in   = 2'd0;
      end else if (bund_done) begin
         bund_valid_in = 1'b0;
      end else if (rsp_accept) begin
         bund_idx_in   = bund_idx_ff + 2'd1;
      end
   end

   assign mode_in = csr_wr_en ? csr_wr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         st_ff         <= STATE_RESET;
         mode_ff       <= 1'b1;
         bund_valid_ff <= 1'b0;
         bund_cnt_ff   <= 2'd0;
         bund_idx_ff   <= 2'd0;
      end else begin
         in_valid_ff   <= in_valid_in;
         mode_ff       <= mode_in;
         bund_valid_ff <= bund_valid_in;
         bund_cnt_ff   <= bund_cnt_in;
         bund_idx_ff   <= bund_idx_in;
         if (adv) begin
            st_ff <= st_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_char_ff <= req_text_char;
         in_eoi_ff  <= req_end_of_input;
      end
      if (load_bund) begin
         bund_res_ff <= step_res;
      end
   end

   assign cur_res           = bund_res_ff[bund_idx_ff];
   assign rsp_valid         = bund_valid_ff;
   assign rsp_kind          = cur_res.kind;
   assign rsp_data_byte     = cur_res.data_byte;
   assign rsp_error_code    = cur_res.error_code;
   assign rsp_packet_length = cur_res.packet_length;
   assign rsp_oversize      = cur_res.oversize;
   assign rsp_last          = (bund_idx_ff == bund_cnt_ff - 2'd1);

   // The delivery index always points inside the loaded bundle.
   `HPTD_ASSERT_NOW(a_idx_in_bundle, bund_valid_ff, bund_idx_ff < bund_cnt_ff && bund_cnt_ff != 2'd0, "bundle index out of range")

   // After an error, only end of input may produce results.
   `HPTD_ASSERT_NOW(a_halt_silent, in_valid_ff && st_ff.error_halt && !in_eoi_ff, step_cnt == 2'd0, "result produced while halted on error")

   // The input-done word is always the final result of its input word.
   `HPTD_ASSERT_NOW(a_done_is_last, bund_valid_ff && cur_res.kind == KIND_DONE, rsp_last, "input done not marked last")

   // A word decoded past a busy bundle must have produced nothing.
   `HPTD_ASSERT_NOW(a_no_overwrite, adv && bund_valid_ff && !bund_done, step_cnt == 2'd0, "bundle overwritten before drained")

   // End of input leaves the parser in its idle state.
   `HPTD_ASSERT_NEXT(a_eoi_clears, adv && in_eoi_ff, st_ff == STATE_RESET, "state not cleared after end of input")

endmodule
